// ===== rtl/gasr_pkg.sv =====
// Shared types, constants and helper functions of the grid route planner.
package gasr_pkg;

   localparam int GRID_W     = 20;
   localparam int GRID_H     = 20;
   localparam int OPEN_DEPTH = 2048;
   localparam int NCELLS     = GRID_W * GRID_H;
   localparam int CELL_AW    = $clog2(NCELLS);
   localparam int COORD_W    = 5;
   localparam int CMD_W      = 2;
   localparam int IDX_W      = 9;
   localparam int LEN_W      = 9;
   localparam int STATUS_W   = 2;
   localparam int COST_W     = 9;
   localparam int F_W        = 10;
   localparam int H_W        = COORD_W + 1;
   localparam int DIR_W      = 2;
   localparam int HEAP_AW    = $clog2(OPEN_DEPTH);
   localparam int CNT_W      = HEAP_AW + 1;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic [F_W-1:0]   f;
      coord_type        x;
      coord_type        y;
      logic [CNT_W-1:0] seq;
   } heap_item_type;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic              closed;
      logic [DIR_W-1:0]  dir;
   } node_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      coord_type        cell_x;
      coord_type        cell_y;
      logic             blocked;
      coord_type        start_x;
      coord_type        start_y;
      coord_type        goal_x;
      coord_type        goal_y;
      logic [IDX_W-1:0] route_index;
   } req_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_RDROUTE, ST_CHKGOAL, ST_INIT, ST_SEED,
      ST_PU_START, ST_PU_UP, ST_PU_CMP, ST_POP_CHECK, ST_POP_TOP, ST_POP_LAST,
      ST_POP_L, ST_POP_R, ST_POP_RCMP, ST_POP_MOVE, ST_POP_END, ST_EXPAND,
      ST_EXP_NODE, ST_NB, ST_NB_EVAL, ST_NB_NEXT, ST_TR_LEN, ST_TR_STEP,
      ST_TR_PAR, ST_RESP
   } state_type;

   function automatic logic earlier(input heap_item_type a, input heap_item_type b);
      return (a.f < b.f) || ((a.f == b.f) && (a.seq < b.seq));
   endfunction

   function automatic logic in_grid(input coord_type x, input coord_type y);
      return (int'(x) < GRID_W) && (int'(y) < GRID_H);
   endfunction

   function automatic logic [CELL_AW-1:0] cell_addr(input coord_type x, input coord_type y);
      return CELL_AW'(int'(y) * GRID_W + int'(x));
   endfunction

   function automatic logic [H_W-1:0] manhattan(input coord_type ax, input coord_type ay,
                                                input coord_type bx, input coord_type by);
      coord_type dx;
      coord_type dy;
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      return H_W'(dx) + H_W'(dy);
   endfunction

endpackage

// ===== rtl/gasr_req_if.sv =====
// Request channel of the grid route planner.
interface gasr_req_if;
   import gasr_pkg::*;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   coord_type        cell_x;
   coord_type        cell_y;
   logic             blocked;
   coord_type        start_x;
   coord_type        start_y;
   coord_type        goal_x;
   coord_type        goal_y;
   logic [IDX_W-1:0] route_index;

   modport source (output valid, cmd, cell_x, cell_y, blocked, start_x, start_y,
                   goal_x, goal_y, route_index, input ready);
   modport sink (input valid, cmd, cell_x, cell_y, blocked, start_x, start_y,
                 goal_x, goal_y, route_index, output ready);
endinterface

// ===== rtl/gasr_rsp_if.sv =====
// Response channel of the grid route planner.
interface gasr_rsp_if;
   import gasr_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    route_length;
   coord_type           step_x;
   coord_type           step_y;

   modport source (output valid, status, route_length, step_x, step_y, input ready);
   modport sink (input valid, status, route_length, step_x, step_y, output ready);
endinterface

// ===== rtl/grid_astar_route_planner_core.sv =====
// Top level of the grid route planner: obstacle map, A* sequencer and route store.
// A find sweeps the node table, then for each expanded cell it pops the open list
// and takes up to 4 neighbour steps with a push.
// Throughput: one transaction at a time; the heap memory port and the shared compare set the pace.
// Reset: synchronous; afterwards a sweep clears the obstacle map before req_ch.ready.
// A finished response waits in its output register while the next request is taken.
module grid_astar_route_planner_core (
   input logic          clock,
   input logic          reset,
   gasr_req_if.sink     req_ch,
   gasr_rsp_if.source   rsp_ch
);
   import gasr_pkg::*;

   localparam int HEAP_W  = $bits(heap_item_type);
   localparam int NODE_W  = $bits(node_type);
   localparam int ROUTE_W = 2 * COORD_W;

   state_type state_ff, state_in;
   logic [CELL_AW-1:0] clr_cnt_ff, clr_cnt_in;
   req_type req_ff, req_in;
   logic [LEN_W-1:0] stored_len_ff, stored_len_in;
   logic [CNT_W-1:0] open_cnt_ff, open_cnt_in;
   logic [CNT_W-1:0] seq_ff, seq_in;
   heap_item_type cur_ff, cur_in, last_ff, last_in, cand_ff, cand_in, item_ff, item_in;
   logic [HEAP_AW-1:0] i_ff, i_in, m_ff, m_in;
   logic [COST_W-1:0] gcur_ff, gcur_in;
   logic [DIR_W-1:0] dir_ff, dir_in;
   logic push_ret_ff, push_ret_in;
   coord_type px_ff, px_in, py_ff, py_in;
   logic [LEN_W-1:0] j_ff, j_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   coord_type step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   coord_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic obs_we, obs_wdata, obs_rdata;
   logic [CELL_AW-1:0] obs_waddr, obs_raddr;
   logic node_we;
   logic [CELL_AW-1:0] node_waddr, node_raddr;
   node_type node_wdata, node_rd;
   logic [NODE_W-1:0] node_rdata;
   logic heap_we;
   logic [HEAP_AW-1:0] heap_waddr, heap_raddr;
   heap_item_type heap_wdata, heap_rd;
   logic [HEAP_W-1:0] heap_rdata;
   logic route_we;
   logic [CELL_AW-1:0] route_waddr, route_raddr;
   logic [ROUTE_W-1:0] route_wdata, route_rdata;

   logic [CELL_AW-1:0] cur_addr, goal_addr, start_addr, nb_addr;
   coord_type nb_x, nb_y;
   logic nb_ok, at_goal, heap_full, ends_ok, idx_ok, rsp_load, cmp_res, last_clr;
   heap_item_type cmp_a, cmp_b;
   logic [COST_W-1:0] ng;
   logic [F_W-1:0] nb_f;
   logic [HEAP_AW:0] l_idx;
   logic [HEAP_AW+1:0] r_idx;
   logic [HEAP_AW-1:0] p_idx;

   gasr_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_obs_ram (
      .clock(clock), .wr_en(obs_we), .wr_addr(obs_waddr), .wr_data(obs_wdata),
      .rd_addr(obs_raddr), .rd_data(obs_rdata));

   gasr_ram #(.WIDTH(NODE_W), .DEPTH(NCELLS)) u_node_ram (
      .clock(clock), .wr_en(node_we), .wr_addr(node_waddr), .wr_data(node_wdata),
      .rd_addr(node_raddr), .rd_data(node_rdata));

   gasr_ram #(.WIDTH(HEAP_W), .DEPTH(OPEN_DEPTH)) u_heap_ram (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_waddr), .wr_data(heap_wdata),
      .rd_addr(heap_raddr), .rd_data(heap_rdata));

   gasr_ram #(.WIDTH(ROUTE_W), .DEPTH(NCELLS)) u_route_ram (
      .clock(clock), .wr_en(route_we), .wr_addr(route_waddr), .wr_data(route_wdata),
      .rd_addr(route_raddr), .rd_data(route_rdata));

   assign node_rd    = node_type'(node_rdata);
   assign heap_rd    = heap_item_type'(heap_rdata);
   assign cur_addr   = cell_addr(cur_ff.x, cur_ff.y);
   assign goal_addr  = cell_addr(req_ff.goal_x, req_ff.goal_y);
   assign start_addr = cell_addr(req_ff.start_x, req_ff.start_y);
   assign nb_addr    = cell_addr(nb_x, nb_y);
   assign at_goal    = (cur_ff.x == req_ff.goal_x) && (cur_ff.y == req_ff.goal_y);
   assign heap_full  = open_cnt_ff >= CNT_W'(OPEN_DEPTH);
   assign ends_ok    = in_grid(req_ff.start_x, req_ff.start_y)
                       && in_grid(req_ff.goal_x, req_ff.goal_y);
   assign idx_ok     = req_ff.route_index < stored_len_ff;
   assign rsp_load   = !rsp_valid_ff || rsp_ch.ready;
   assign last_clr   = clr_cnt_ff == CELL_AW'(NCELLS - 1);
   assign ng         = gcur_ff + 1'b1;
   assign nb_f       = F_W'(ng) + F_W'(manhattan(nb_x, nb_y, req_ff.goal_x, req_ff.goal_y));
   assign l_idx      = {i_ff, 1'b1};
   assign r_idx      = (HEAP_AW + 2)'(l_idx) + 1'b1;
   assign p_idx      = (i_ff - 1'b1) >> 1;
   assign cmp_res    = earlier(cmp_a, cmp_b);

   always_comb begin
      nb_x  = cur_ff.x;
      nb_y  = cur_ff.y;
      nb_ok = 1'b0;
      unique case (dir_ff)
         DIR_UP: begin
            nb_y  = cur_ff.y - 1'b1;
            nb_ok = cur_ff.y != '0;
         end
         DIR_DOWN: begin
            nb_y  = cur_ff.y + 1'b1;
            nb_ok = int'(cur_ff.y) < GRID_H - 1;
         end
         DIR_LEFT: begin
            nb_x  = cur_ff.x - 1'b1;
            nb_ok = cur_ff.x != '0;
         end
         DIR_RIGHT: begin
            nb_x  = cur_ff.x + 1'b1;
            nb_ok = int'(cur_ff.x) < GRID_W - 1;
         end
         default: nb_ok = 1'b0;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_PU_CMP: begin
            cmp_a = item_ff;
            cmp_b = heap_rd;
         end
         ST_POP_RCMP: begin
            cmp_a = heap_rd;
            cmp_b = cand_ff;
         end
         default: begin
            cmp_a = cand_ff;
            cmp_b = last_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     state_in = last_clr ? ST_IDLE : ST_CLEAR;
         ST_IDLE:      state_in = req_ch.valid ? ST_DECODE : ST_IDLE;
         ST_DECODE: begin
            case (req_ff.cmd)
               CMD_SET:  state_in = ST_RESP;
               CMD_FIND: state_in = ends_ok ? ST_CHKGOAL : ST_RESP;
               CMD_READ: state_in = idx_ok ? ST_RDROUTE : ST_RESP;
               default:  state_in = ST_RESP;
            endcase
         end
         ST_RDROUTE:   state_in = ST_RESP;
         ST_CHKGOAL:   state_in = obs_rdata ? ST_RESP : ST_INIT;
         ST_INIT:      state_in = last_clr ? ST_SEED : ST_INIT;
         ST_SEED:      state_in = ST_PU_START;
         ST_PU_START: begin
            if (heap_full) begin
               state_in = push_ret_ff ? ST_NB_NEXT : ST_POP_CHECK;
            end else begin
               state_in = ST_PU_UP;
            end
         end
         ST_PU_UP: begin
            if (i_ff == '0) begin
               state_in = push_ret_ff ? ST_NB_NEXT : ST_POP_CHECK;
            end else begin
               state_in = ST_PU_CMP;
            end
         end
         ST_PU_CMP: begin
            if (cmp_res) begin
               state_in = ST_PU_UP;
            end else begin
               state_in = push_ret_ff ? ST_NB_NEXT : ST_POP_CHECK;
            end
         end
         ST_POP_CHECK: state_in = (open_cnt_ff == '0) ? ST_RESP : ST_POP_TOP;
         ST_POP_TOP:   state_in = ST_POP_LAST;
         ST_POP_LAST:  state_in = ST_POP_L;
         ST_POP_L:     state_in = (l_idx < open_cnt_ff) ? ST_POP_R : ST_POP_END;
         ST_POP_R:     state_in = (r_idx < (HEAP_AW + 2)'(open_cnt_ff)) ? ST_POP_RCMP
                                                                         : ST_POP_MOVE;
         ST_POP_RCMP:  state_in = ST_POP_MOVE;
         ST_POP_MOVE:  state_in = cmp_res ? ST_POP_L : ST_POP_END;
         ST_POP_END:   state_in = ST_EXPAND;
         ST_EXPAND:    state_in = at_goal ? ST_TR_LEN : ST_EXP_NODE;
         ST_EXP_NODE:  state_in = node_rd.closed ? ST_POP_CHECK : ST_NB;
         ST_NB:        state_in = nb_ok ? ST_NB_EVAL : ST_NB_NEXT;
         ST_NB_EVAL:   state_in = (!obs_rdata && (ng < node_rd.cost)) ? ST_PU_START
                                                                      : ST_NB_NEXT;
         ST_NB_NEXT:   state_in = (dir_ff == DIR_RIGHT) ? ST_POP_CHECK : ST_NB;
         ST_TR_LEN:    state_in = ST_TR_STEP;
         ST_TR_STEP:   state_in = (j_ff == '0) ? ST_RESP : ST_TR_PAR;
         ST_TR_PAR:    state_in = ST_TR_STEP;
         ST_RESP:      state_in = rsp_load ? ST_IDLE : ST_RESP;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      req_in        = req_ff;
      stored_len_in = stored_len_ff;
      open_cnt_in   = open_cnt_ff;
      seq_in        = seq_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      cand_in       = cand_ff;
      item_in       = item_ff;
      i_in          = i_ff;
      m_in          = m_ff;
      gcur_in       = gcur_ff;
      dir_in        = dir_ff;
      push_ret_in   = push_ret_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      j_in          = j_ff;
      status_in     = status_ff;
      step_x_in     = step_x_ff;
      step_y_in     = step_y_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      obs_we        = 1'b0;
      obs_waddr     = '0;
      obs_wdata     = 1'b0;
      obs_raddr     = '0;
      node_we       = 1'b0;
      node_waddr    = '0;
      node_wdata    = '0;
      node_raddr    = '0;
      heap_we       = 1'b0;
      heap_waddr    = '0;
      heap_wdata    = '0;
      heap_raddr    = '0;
      route_we      = 1'b0;
      route_waddr   = '0;
      route_wdata   = '0;
      route_raddr   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            obs_we     = 1'b1;
            obs_waddr  = clr_cnt_ff;
            clr_cnt_in = last_clr ? '0 : clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               req_in.cmd         = req_ch.cmd;
               req_in.cell_x      = req_ch.cell_x;
               req_in.cell_y      = req_ch.cell_y;
               req_in.blocked     = req_ch.blocked;
               req_in.start_x     = req_ch.start_x;
               req_in.start_y     = req_ch.start_y;
               req_in.goal_x      = req_ch.goal_x;
               req_in.goal_y      = req_ch.goal_y;
               req_in.route_index = req_ch.route_index;
            end
         end
         ST_DECODE: begin
            status_in = STATUS_OK;
            step_x_in = '0;
            step_y_in = '0;
            case (req_ff.cmd)
               CMD_SET: begin
                  if (in_grid(req_ff.cell_x, req_ff.cell_y)) begin
                     obs_we    = 1'b1;
                     obs_waddr = cell_addr(req_ff.cell_x, req_ff.cell_y);
                     obs_wdata = req_ff.blocked;
                  end
               end
               CMD_FIND: begin
                  stored_len_in = '0;
                  obs_raddr     = goal_addr;
                  if (!ends_ok) begin
                     status_in = STATUS_FAIL;
                  end
               end
               CMD_READ: begin
                  route_raddr = CELL_AW'(req_ff.route_index);
                  if (!idx_ok) begin
                     status_in = STATUS_RANGE;
                  end
               end
               default: status_in = STATUS_FAIL;
            endcase
         end
         ST_RDROUTE: begin
            step_x_in = route_rdata[COORD_W-1:0];
            step_y_in = route_rdata[ROUTE_W-1:COORD_W];
         end
         ST_CHKGOAL: begin
            if (obs_rdata) begin
               status_in = STATUS_FAIL;
            end
         end
         ST_INIT: begin
            node_we    = 1'b1;
            node_waddr = clr_cnt_ff;
            node_wdata = '{cost: COST_MAX, closed: 1'b0, dir: DIR_UP};
            clr_cnt_in = last_clr ? '0 : clr_cnt_ff + 1'b1;
         end
         ST_SEED: begin
            node_we      = 1'b1;
            node_waddr   = start_addr;
            node_wdata   = '{cost: '0, closed: 1'b0, dir: DIR_UP};
            open_cnt_in  = '0;
            seq_in       = '0;
            item_in.f    = F_W'(manhattan(req_ff.start_x, req_ff.start_y,
                                          req_ff.goal_x, req_ff.goal_y));
            item_in.x    = req_ff.start_x;
            item_in.y    = req_ff.start_y;
            item_in.seq  = '0;
            push_ret_in  = 1'b0;
         end
         ST_PU_START: begin
            if (!heap_full) begin
               item_in.seq = seq_ff;
               seq_in      = seq_ff + 1'b1;
               i_in        = HEAP_AW'(open_cnt_ff);
               open_cnt_in = open_cnt_ff + 1'b1;
            end
         end
         ST_PU_UP: begin
            if (i_ff == '0) begin
               heap_we    = 1'b1;
               heap_waddr = '0;
               heap_wdata = item_ff;
            end else begin
               heap_raddr = p_idx;
            end
         end
         ST_PU_CMP: begin
            heap_we    = 1'b1;
            heap_waddr = i_ff;
            if (cmp_res) begin
               heap_wdata = heap_rd;
               i_in       = p_idx;
            end else begin
               heap_wdata = item_ff;
            end
         end
         ST_POP_CHECK: begin
            heap_raddr = '0;
            if (open_cnt_ff == '0) begin
               status_in = STATUS_FAIL;
            end
         end
         ST_POP_TOP: begin
            cur_in      = heap_rd;
            open_cnt_in = open_cnt_ff - 1'b1;
            heap_raddr  = HEAP_AW'(open_cnt_ff - 1'b1);
         end
         ST_POP_LAST: begin
            last_in = heap_rd;
            i_in    = '0;
         end
         ST_POP_L: heap_raddr = HEAP_AW'(l_idx);
         ST_POP_R: begin
            cand_in    = heap_rd;
            m_in       = HEAP_AW'(l_idx);
            heap_raddr = HEAP_AW'(r_idx);
         end
         ST_POP_RCMP: begin
            if (cmp_res) begin
               cand_in = heap_rd;
               m_in    = HEAP_AW'(r_idx);
            end
         end
         ST_POP_MOVE: begin
            if (cmp_res) begin
               heap_we    = 1'b1;
               heap_waddr = i_ff;
               heap_wdata = cand_ff;
               i_in       = m_ff;
            end
         end
         ST_POP_END: begin
            if (open_cnt_ff != '0) begin
               heap_we    = 1'b1;
               heap_waddr = i_ff;
               heap_wdata = last_ff;
            end
         end
         ST_EXPAND: node_raddr = at_goal ? goal_addr : cur_addr;
         ST_EXP_NODE: begin
            if (!node_rd.closed) begin
               node_we    = 1'b1;
               node_waddr = cur_addr;
               node_wdata = '{cost: node_rd.cost, closed: 1'b1, dir: node_rd.dir};
               gcur_in    = node_rd.cost;
               dir_in     = DIR_UP;
            end
         end
         ST_NB: begin
            obs_raddr  = nb_addr;
            node_raddr = nb_addr;
         end
         ST_NB_EVAL: begin
            if (!obs_rdata && (ng < node_rd.cost)) begin
               node_we     = 1'b1;
               node_waddr  = nb_addr;
               node_wdata  = '{cost: ng, closed: node_rd.closed, dir: dir_ff};
               item_in.f   = nb_f;
               item_in.x   = nb_x;
               item_in.y   = nb_y;
               item_in.seq = '0;
               push_ret_in = 1'b1;
            end
         end
         ST_NB_NEXT: dir_in = dir_ff + 1'b1;
         ST_TR_LEN: begin
            stored_len_in = LEN_W'(node_rd.cost);
            j_in          = LEN_W'(node_rd.cost);
            px_in         = req_ff.goal_x;
            py_in         = req_ff.goal_y;
         end
         ST_TR_STEP: begin
            if (j_ff != '0) begin
               route_we    = 1'b1;
               route_waddr = CELL_AW'(j_ff - 1'b1);
               route_wdata = {py_ff, px_ff};
               node_raddr  = cell_addr(px_ff, py_ff);
            end
         end
         ST_TR_PAR: begin
            j_in = j_ff - 1'b1;
            unique case (node_rd.dir)
               DIR_UP:    py_in = py_ff + 1'b1;
               DIR_DOWN:  py_in = py_ff - 1'b1;
               DIR_LEFT:  px_in = px_ff + 1'b1;
               DIR_RIGHT: px_in = px_ff - 1'b1;
               default:   px_in = px_ff;
            endcase
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_len_in    = stored_len_ff;
               rsp_x_in      = step_x_ff;
               rsp_y_in      = step_y_ff;
            end
         end
         default: rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         stored_len_ff <= '0;
         open_cnt_ff   <= '0;
         seq_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         stored_len_ff <= stored_len_in;
         open_cnt_ff   <= open_cnt_in;
         seq_ff        <= seq_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      cur_ff        <= cur_in;
      last_ff       <= last_in;
      cand_ff       <= cand_in;
      item_ff       <= item_in;
      i_ff          <= i_in;
      m_ff          <= m_in;
      gcur_ff       <= gcur_in;
      dir_ff        <= dir_in;
      push_ret_ff   <= push_ret_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      j_ff          <= j_in;
      status_ff     <= status_in;
      step_x_ff     <= step_x_in;
      step_y_ff     <= step_y_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

   assign req_ch.ready        = state_ff == ST_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.route_length = rsp_len_ff;
   assign rsp_ch.step_x       = rsp_x_ff;
   assign rsp_ch.step_y       = rsp_y_ff;

   // The open list never holds more entries than the heap memory has rows.
   assert property (@(posedge clock) disable iff (reset)
      open_cnt_ff <= CNT_W'(OPEN_DEPTH))
      else $error("open list count exceeds heap depth");

   // A stored route is always shorter than the number of grid cells.
   assert property (@(posedge clock) disable iff (reset)
      int'(stored_len_ff) < NCELLS)
      else $error("stored route longer than the grid");

   // The trace-back never writes beyond the route length it has just stored.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TR_STEP) |-> (j_ff <= stored_len_ff))
      else $error("route trace index beyond stored length");

   // Finishing a transaction always leaves a response waiting in the output register.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("response lost on completion");
endmodule

// ===== rtl/gasr_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module gasr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
